FILE: sv/swm_pkg.sv
package swm_pkg;

   // sequencer states of the top level
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } swm_state_type;

endpackage

FILE: sv/swm_cell.sv
module swm_cell #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           shift_en,
   input  logic signed [SAMPLE_WIDTH-1:0] smp_prev,
   input  logic signed [SAMPLE_WIDTH-1:0] acc_prev,
   output logic signed [SAMPLE_WIDTH-1:0] smp,
   output logic signed [SAMPLE_WIDTH-1:0] acc
);

   logic signed [SAMPLE_WIDTH-1:0] smp_ff;
   logic signed [SAMPLE_WIDTH-1:0] acc_ff;
   logic signed [SAMPLE_WIDTH-1:0] smp_in;
   logic signed [SAMPLE_WIDTH-1:0] acc_in;

   always_comb begin
      smp_in = shift_en ? smp_prev : smp_ff;
      // running max: own sample against what the left neighbor has so far
      acc_in = (smp_ff > acc_prev) ? smp_ff : acc_prev;
   end

   always_ff @(posedge clock) begin
      smp_ff <= smp_in;
      acc_ff <= acc_in;
   end

   assign smp = smp_ff;
   assign acc = acc_ff;

endmodule

FILE: sv/swm_chain.sv
module swm_chain #(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 16,
   parameter int IW           = 6
) (
   input  logic                           clock,
   input  logic                           shift_en,
   input  logic signed [SAMPLE_WIDTH-1:0] smp_in,
   input  logic        [IW-1:0]           sel,
   output logic signed [SAMPLE_WIDTH-1:0] max_out
);

   localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEG =
      {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [SAMPLE_WIDTH-1:0] smp_q [WINDOW_MAX];
   logic signed [SAMPLE_WIDTH-1:0] acc_q [WINDOW_MAX];

   // cell 0 holds the newest sample, cell i the one i requests back
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      if (i == 0) begin : g_head
         swm_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .smp_prev (smp_in),
            .acc_prev (MOST_NEG),
            .smp      (smp_q[i]),
            .acc      (acc_q[i])
         );
      end else begin : g_body
         swm_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .smp_prev (smp_q[i-1]),
            .acc_prev (acc_q[i-1]),
            .smp      (smp_q[i]),
            .acc      (acc_q[i])
         );
      end
   end

   assign max_out = acc_q[sel];

endmodule

FILE: sv/sliding_window_max_top.sv
// Channel  Ports                                  Contents
// req      req_tvalid/tready/tdata/tlast          sample in tdata, last_sample in tlast
// rsp      rsp_tvalid/tready/tdata/tlast          window_max in tdata, final_result in tlast
// csr      csr_wr_en/csr_wr_data                  window_size
//
// A request that completes a window (k = effective window) starts a scan:
// the running max ripples one cell per cycle down the compare chain, read out at cell k-1.
// A request that yields no result leaves the sequencer idle for the next request.
// Reset clears the sequencer, fill count and output valid; window_size goes to 1.
// The result waits in an output register, so the next request is taken while it stalls.
module sliding_window_max_top
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,

   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,  // [SW-1:0] sample
   input  logic                            req_tlast,

   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] rsp_tdata,  // [SW-1:0] window_max
   output logic                            rsp_tlast,

   input  logic                            csr_wr_en,
   input  logic [6:0]                      csr_wr_data
);

   localparam int DW   = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int KW   = $clog2(WINDOW_MAX + 1);
   localparam int IW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CMPW = (KW > 7) ? KW : 7;

   swm_state_type state_ff, state_in;

   logic [6:0]    csr_ff;
   logic [KW-1:0] fill_ff, fill_in, fill_inc;
   logic [KW-1:0] kk_ff, kk_in, k_eff;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_last_ff, rsp_last_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic signed [SAMPLE_WIDTH-1:0] chain_max;
   logic [CMPW-1:0] csr_x;

   logic accept, rsp_free, load, hit;

   // effective window: 0 acts as 1, above WINDOW_MAX clamps
   always_comb begin
      csr_x = CMPW'(csr_ff);
      if (csr_x == '0) begin
         k_eff = KW'(1);
      end else if (csr_x > CMPW'(WINDOW_MAX)) begin
         k_eff = KW'(WINDOW_MAX);
      end else begin
         k_eff = csr_x[KW-1:0];
      end
   end

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign fill_inc = (fill_ff < KW'(WINDOW_MAX)) ? fill_ff + KW'(1) : fill_ff;
   assign hit      = fill_inc >= k_eff;
   assign load     = (state_ff == ST_SCAN) && (cnt_ff == kk_ff) && rsp_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && hit) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_SCAN: req_tready = 1'b0;
         default: req_tready = 1'b0;
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      kk_in   = kk_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      if (accept) begin
         fill_in = req_tlast ? '0 : fill_inc;
         kk_in   = k_eff;
         cnt_in  = '0;
         last_in = req_tlast;
      end else if (state_ff == ST_SCAN && cnt_ff != kk_ff) begin
         cnt_in = cnt_ff + KW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = chain_max;
         rsp_last_in  = last_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= 7'd1;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) csr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      kk_ff       <= kk_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   swm_chain #(
      .WINDOW_MAX   (WINDOW_MAX),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .IW           (IW)
   ) u_chain (
      .clock    (clock),
      .shift_en (accept),
      .smp_in   (req_tdata[SAMPLE_WIDTH-1:0]),
      .sel      (IW'(kk_ff - KW'(1))),
      .max_out  (chain_max)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DW'($unsigned(rsp_data_ff));
   assign rsp_tlast  = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= KW'(WINDOW_MAX))
      else $error("fill count above window depth");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cnt_ff <= kk_ff)
      else $error("scan counter ran past window");

   a_hit_scan: assert property (@(posedge clock) disable iff (reset)
      accept && hit |=> state_ff == ST_SCAN)
      else $error("full window did not start a scan");

   a_last_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> fill_ff == '0)
      else $error("last request did not clear the window");

   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      load |-> cnt_ff != '0 && !req_tready)
      else $error("result loaded before the chain settled");

endmodule
